### src/hidub_pkg.sv
// Package: shared types, codes and constants of the HID usage builder.
package hidub_pkg;

    localparam logic [4:0] FN_PAGE    = 5'd0;
    localparam logic [4:0] FN_USAGE   = 5'd1;
    localparam logic [4:0] FN_UMIN    = 5'd2;
    localparam logic [4:0] FN_UMAX    = 5'd3;
    localparam logic [4:0] FN_REPID   = 5'd4;
    localparam logic [4:0] FN_LMIN    = 5'd5;
    localparam logic [4:0] FN_LMAX    = 5'd6;
    localparam logic [4:0] FN_PMIN    = 5'd7;
    localparam logic [4:0] FN_PMAX    = 5'd8;
    localparam logic [4:0] FN_EXP     = 5'd9;
    localparam logic [4:0] FN_UNIT    = 5'd10;
    localparam logic [4:0] FN_SIZE    = 5'd11;
    localparam logic [4:0] FN_COUNT   = 5'd12;
    localparam logic [4:0] FN_INPUT   = 5'd13;
    localparam logic [4:0] FN_OUTPUT  = 5'd14;
    localparam logic [4:0] FN_FEATURE = 5'd15;
    localparam logic [4:0] FN_COLL    = 5'd16;
    localparam logic [4:0] FN_ENDCOLL = 5'd17;

    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_DESKTOP = 3'd1;
    localparam logic [2:0] KIND_BUTTON  = 3'd2;
    localparam logic [2:0] KIND_VENDOR  = 3'd3;
    localparam logic [2:0] KIND_PADDING = 3'd4;
    localparam logic [2:0] KIND_REPID   = 3'd5;

    localparam logic [31:0] PAGE_DESKTOP = 32'h0000_0001;
    localparam logic [31:0] PAGE_BUTTON  = 32'h0000_0009;
    localparam logic [31:0] PAGE_VENDOR  = 32'h0000_FF00;
    localparam logic [31:0] REPID_BITS   = 32'd8;
    localparam logic [31:0] COLL_APP     = 32'd1;

    typedef struct packed {
        logic [4:0]  func;
        logic [31:0] item_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  report_number;
        logic [2:0]  usage_kind;
        logic [31:0] usage_low;
        logic [31:0] usage_high;
        logic [1:0]  io_kind;
        logic [31:0] logical_low;
        logic [31:0] logical_high;
        logic [31:0] unit_code;
        logic [31:0] unit_power;
        logic [31:0] field_bits;
        logic [31:0] field_count;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BOUND,
        ST_DIV,
        ST_REPID,
        ST_RD,
        ST_RDWAIT,
        ST_EMIT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic simple;     // apply a global or usage item
        logic pad;        // push padding (main) or empty usage (bounds) if list empty
        logic bound_wr;   // write the bound into entry idx
        logic idx_clr;
        logic idx_inc;
        logic div_start;
        logic rd;         // issue a list read at idx
        logic out_repid;  // load the report-id record into the output register
        logic out_list;   // load a list record into the output register
        logic clr_list;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_bound;
        logic is_main;
        logic is_coll;
        logic list_empty;
        logic idx_at_end;  // idx is the last pending entry
        logic div_done;
        logic repid_pend;
        logic out_full;
    } dp_sts_t;

endpackage

### src/hidub_ram.sv
// Generic single-port-write RAM with registered read.
module hidub_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/hidub_div.sv
// Restoring divider, one quotient bit a cycle.
module hidub_div #(
    parameter int DW = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [31:0]   dividend,
    input  logic [DW-1:0] divisor,
    output logic [31:0]   quotient,
    output logic          done
);
    logic [31:0]   quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DW-1:0], quo_reg[31]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = !busy_reg && !start;
endmodule

### src/hidub_ctrl.sv
// Controller state machine of the HID usage builder.
module hidub_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hidub_pkg::dp_sts_t sts,
    output hidub_pkg::dp_cmd_t cmd
);
    import hidub_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_DECODE;
            ST_DECODE: begin
                if (sts.is_bound) state_next = ST_BOUND;
                else if (sts.is_main) state_next = ST_DIV;
                else if (sts.is_coll && !sts.list_empty) state_next = ST_RD;
                else state_next = ST_IDLE;
            end
            ST_BOUND:  if (sts.idx_at_end) state_next = ST_IDLE;
            ST_DIV:    if (sts.div_done) state_next = sts.repid_pend ? ST_REPID : ST_RD;
            ST_REPID:  if (!sts.out_full) state_next = ST_RD;
            ST_RD:     state_next = ST_RDWAIT;
            ST_RDWAIT: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!sts.out_full) state_next = sts.idx_at_end ? ST_IDLE : ST_RD;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DECODE: begin
                cmd.simple  = 1'b1;
                cmd.pad     = sts.is_bound || sts.is_main;
                cmd.idx_clr = 1'b1;
            end
            ST_BOUND: begin
                cmd.bound_wr = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            ST_DIV: begin
                cmd.div_start = 1'b0;
            end
            ST_REPID:  cmd.out_repid = !sts.out_full;
            ST_RD:     cmd.rd = 1'b1;
            ST_RDWAIT: cmd.rd = 1'b0;
            ST_EMIT: begin
                cmd.out_list = !sts.out_full;
                cmd.idx_inc  = !sts.out_full;
                cmd.clr_list = !sts.out_full && sts.idx_at_end;
            end
            default: cmd = '0;
        endcase
        if (state_reg == ST_DECODE && sts.is_main) begin
            cmd.div_start = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !sts.out_full) |-> cmd.out_list)
        else $error("emit state did not load the output register");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |=> (state_reg == ST_RDWAIT))
        else $error("list read not followed by wait");
endmodule

### src/hidub_dp.sv
// Datapath: item state, usage list memories, divider and output register.
module hidub_dp #(
    parameter int MAX_USAGES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hidub_pkg::in_item_t  s_item,
    input  hidub_pkg::dp_cmd_t   cmd,
    output hidub_pkg::dp_sts_t   sts,
    output hidub_pkg::out_item_t m_item,
    output logic                 m_valid,
    input  logic                 m_ready
);
    import hidub_pkg::*;

    localparam int AW = (MAX_USAGES > 1) ? $clog2(MAX_USAGES) : 1;
    localparam int LW = $clog2(MAX_USAGES + 1);

    logic [4:0]    func_reg;
    logic [31:0]   val_reg;
    logic [2:0]    page_reg;
    logic [31:0]   repid_reg, llo_reg, lhi_reg, unit_reg, pow_reg, size_reg, cnt_reg;
    logic [7:0]    rnum_reg;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg;
    logic [1:0]    io;
    logic          out_v_reg;
    out_item_t     out_reg;

    logic [AW-1:0] waddr;
    logic [2:0]    wkind;
    logic [31:0]   wlo, whi;
    logic [2:0]    rkind;
    logic [31:0]   rlo, rhi;
    logic [31:0]   quo;
    logic          div_done;
    logic          do_push;
    logic [2:0]    push_kind;
    logic [31:0]   push_code;
    logic          is_main;

    assign is_main = func_reg == FN_INPUT || func_reg == FN_OUTPUT
                  || func_reg == FN_FEATURE;
    assign io = is_main ? 2'(func_reg - FN_COUNT) : 2'd0;

    // Usage pushes and bound writes share the memory write port.
    always_comb begin
        do_push   = 1'b0;
        push_kind = page_reg;
        push_code = val_reg;
        if (cmd.simple && func_reg == FN_USAGE) begin
            do_push = 1'b1;
        end
        if (cmd.pad && len_reg == '0) begin
            do_push   = 1'b1;
            push_code = '0;
            if (is_main) push_kind = KIND_PADDING;
        end
        do_push = do_push && (len_reg < LW'(MAX_USAGES));
        len_next = len_reg + LW'(do_push);
        waddr = cmd.bound_wr ? idx_reg[AW-1:0] : len_reg[AW-1:0];
        wkind = push_kind;
        wlo   = push_code;
        whi   = push_code;
    end

    // Kind is never changed by a bound write, so only the bounds are rewritten.
    logic [31:0] lo_wdata, hi_wdata;
    logic        lo_we, hi_we, kind_we;
    assign kind_we  = do_push;
    assign lo_we    = do_push || (cmd.bound_wr && func_reg == FN_UMIN);
    assign hi_we    = do_push || (cmd.bound_wr && func_reg == FN_UMAX);
    assign lo_wdata = cmd.bound_wr ? val_reg : wlo;
    assign hi_wdata = cmd.bound_wr ? val_reg : whi;

    hidub_ram #(.WIDTH(3), .DEPTH(1 << AW)) u_kind (
        .aclk(aclk), .we(kind_we), .waddr(waddr), .wdata(wkind),
        .raddr(idx_reg[AW-1:0]), .rdata(rkind));
    hidub_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_lo (
        .aclk(aclk), .we(lo_we), .waddr(waddr), .wdata(lo_wdata),
        .raddr(idx_reg[AW-1:0]), .rdata(rlo));
    hidub_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_hi (
        .aclk(aclk), .we(hi_we), .waddr(waddr), .wdata(hi_wdata),
        .raddr(idx_reg[AW-1:0]), .rdata(rhi));

    // The divisor is the list length after any padding push.
    hidub_div #(.DW(LW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(cnt_reg), .divisor(len_next), .quotient(quo), .done(div_done));

    logic [2:0] page_map;
    always_comb begin
        if (val_reg == PAGE_DESKTOP) page_map = KIND_DESKTOP;
        else if (val_reg == PAGE_BUTTON) page_map = KIND_BUTTON;
        else if (val_reg == PAGE_VENDOR) page_map = KIND_VENDOR;
        else page_map = KIND_UNKNOWN;
    end

    logic div_wait_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg  <= KIND_UNKNOWN;
            repid_reg <= '0;
            rnum_reg  <= '0;
            llo_reg   <= '0;
            lhi_reg   <= '0;
            unit_reg  <= '0;
            pow_reg   <= '0;
            size_reg  <= '0;
            cnt_reg   <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            out_v_reg <= 1'b0;
            div_wait_reg <= 1'b0;
        end else begin
            len_reg <= cmd.clr_list ? '0 : len_next;
            if (cmd.div_start) div_wait_reg <= 1'b1;
            if (div_wait_reg && div_done) begin
                cnt_reg      <= quo;
                div_wait_reg <= 1'b0;
            end
            if (cmd.simple) begin
                case (func_reg)
                    FN_PAGE:  page_reg  <= page_map;
                    FN_REPID: repid_reg <= val_reg;
                    FN_LMIN:  llo_reg   <= val_reg;
                    FN_LMAX:  lhi_reg   <= val_reg;
                    FN_EXP:   pow_reg   <= val_reg;
                    FN_UNIT:  unit_reg  <= val_reg;
                    FN_SIZE:  size_reg  <= val_reg;
                    FN_COUNT: cnt_reg   <= val_reg;
                    FN_COLL: begin
                        if (val_reg == COLL_APP && rnum_reg != 8'hFF) begin
                            rnum_reg <= rnum_reg + 8'd1;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.idx_clr) idx_reg <= '0;
            else if (cmd.idx_inc) idx_reg <= idx_reg + LW'(1);
            if (cmd.out_repid) repid_reg <= '0;
            if (cmd.out_repid || cmd.out_list) out_v_reg <= 1'b1;
            else if (m_ready) out_v_reg <= 1'b0;
        end
        if (cmd.load) begin
            func_reg <= s_item.func;
            val_reg  <= s_item.item_value;
        end
        if (cmd.out_repid) begin
            out_reg <= '{report_number: rnum_reg, usage_kind: KIND_REPID,
                         usage_low: repid_reg, usage_high: repid_reg, io_kind: io,
                         logical_low: '0, logical_high: '0, unit_code: '0,
                         unit_power: '0, field_bits: REPID_BITS,
                         field_count: 32'd1, last: 1'b0};
        end else if (cmd.out_list) begin
            out_reg <= '{report_number: rnum_reg, usage_kind: rkind,
                         usage_low: rlo, usage_high: rhi, io_kind: io,
                         logical_low: is_main ? llo_reg : '0,
                         logical_high: is_main ? lhi_reg : '0,
                         unit_code: is_main ? unit_reg : '0,
                         unit_power: is_main ? pow_reg : '0,
                         field_bits: is_main ? size_reg : '0,
                         field_count: is_main ? cnt_reg : '0,
                         last: idx_reg + LW'(1) == len_reg};
        end
    end

    assign sts.is_bound   = func_reg == FN_UMIN || func_reg == FN_UMAX;
    assign sts.is_main    = is_main;
    assign sts.is_coll    = func_reg == FN_COLL;
    assign sts.list_empty = len_reg == '0;
    assign sts.idx_at_end = idx_reg + LW'(1) >= len_reg;
    assign sts.div_done   = div_done && !div_wait_reg;
    assign sts.repid_pend = repid_reg != '0;
    assign sts.out_full   = out_v_reg && !m_ready;

    assign m_item  = out_reg;
    assign m_valid = out_v_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_USAGES))
        else $error("usage list overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_list |=> len_reg == '0)
        else $error("list not cleared after emission");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_list || cmd.out_repid) |-> !(out_v_reg && !m_ready))
        else $error("output register overwritten while stalled");
endmodule

### src/hid_descriptor_usage_builder_core.sv
// Top level of the HID descriptor usage builder.
//  channel | direction | payload     | handshake
//  s_      | in        | in_item_t   | s_valid / s_ready
//  m_      | out       | out_item_t  | m_valid / m_ready
// A global or usage item passes through decode only; a usage min/max then writes
// the bound of each pending usage. An input, output or feature item waits for the
// bit-serial count division, emits a report-id record if one is pending, then reads each record from the list RAM.
// A collection item reads and emits each pending usage from the list RAM.
// Reset is synchronous on aresetn; the list RAMs need no clearing.
// A stalled result holds the emission until m_ready returns.
module hid_descriptor_usage_builder_core #(
    parameter int MAX_USAGES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hidub_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hidub_pkg::out_item_t m_item
);
    import hidub_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    hidub_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .sts(sts), .cmd(cmd));

    hidub_dp #(.MAX_USAGES(MAX_USAGES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_item(s_item), .cmd(cmd), .sts(sts),
        .m_item(m_item), .m_valid(m_valid), .m_ready(m_ready));
endmodule
